[hdl/pva_pkg.sv]
// shared types, constants and the arctangent table for the polar vector accumulator
package pva_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int MAG_WIDTH    = 24;

	localparam int NSTEPS  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int MAG_USE = (MAG_WIDTH < 24) ? MAG_WIDTH : 24;
	localparam logic [23:0] MAG_MASK = 24'((25'd1 << MAG_USE) - 25'd1);

	localparam logic [15:0] DEG90  = 16'd11520;
	localparam logic [15:0] DEG180 = 16'd23040;
	localparam logic [15:0] DEG270 = 16'd34560;
	localparam logic [15:0] DEG360 = 16'd46080;

	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
	localparam logic [23:0] GAIN_Q24 = 24'd10188014;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	// classified vector handed from the front to the back
	typedef struct packed {
		logic        restart;
		logic [23:0] mag;
		logic [1:0]  quad;
		logic [13:0] rem;
	} item_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic [22:0] atan_val(input logic [4:0] idx);
		logic [22:0] v;
		case (idx)
			5'd0:  v = 23'd2949120;
			5'd1:  v = 23'd1740967;
			5'd2:  v = 23'd919879;
			5'd3:  v = 23'd466945;
			5'd4:  v = 23'd234379;
			5'd5:  v = 23'd117304;
			5'd6:  v = 23'd58666;
			5'd7:  v = 23'd29335;
			5'd8:  v = 23'd14668;
			5'd9:  v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			5'd20: v = 23'd4;
			5'd21: v = 23'd2;
			5'd22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

[hdl/pva_front.sv]
// front end: wraps the direction and splits it into quadrant and remainder
module pva_front (
	input  logic               restart,
	input  logic [23:0]        vec_magnitude,
	input  logic [15:0]        vec_direction,
	output pva_pkg::item_t     item
);

	logic [15:0] dir;

	always_comb begin
		dir = (vec_direction >= pva_pkg::DEG360) ? vec_direction - pva_pkg::DEG360
			: vec_direction;
		item.restart = restart;
		item.mag     = vec_magnitude & pva_pkg::MAG_MASK;
		if (dir >= pva_pkg::DEG270) begin
			item.quad = pva_pkg::QUAD_IV;
			item.rem  = 14'(dir - pva_pkg::DEG270);
		end else if (dir >= pva_pkg::DEG180) begin
			item.quad = pva_pkg::QUAD_III;
			item.rem  = 14'(dir - pva_pkg::DEG180);
		end else if (dir >= pva_pkg::DEG90) begin
			item.quad = pva_pkg::QUAD_II;
			item.rem  = 14'(dir - pva_pkg::DEG90);
		end else begin
			item.quad = pva_pkg::QUAD_I;
			item.rem  = dir[13:0];
		end
	end

endmodule

[hdl/pva_fifo.sv]
// two-entry queue of classified vectors between front and back
module pva_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  pva_pkg::item_t wr_item,
	output logic           full,
	input  logic           rd,
	output pva_pkg::item_t rd_item,
	output logic           empty
);

	pva_pkg::item_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           do_wr, do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= !wp_q;
			end
			if (do_rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

endmodule

[hdl/pva_back.sv]
// back end: cordic rotation, saturating accumulate, cordic vectoring, result register
module pva_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pva_pkg::item_t      item,
	input  logic                item_valid,
	output logic                item_pop,
	output logic signed [31:0]  sum_x,
	output logic signed [31:0]  sum_y,
	output logic [31:0]         sum_magnitude,
	output logic [15:0]         sum_direction,
	output logic                empty,
	input  logic                pop
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ROT, S_ACC, S_VINIT, S_VEC, S_MLO, S_MHI, S_FIN, S_DONE
	} state_t;

	localparam logic [4:0] LAST = 5'(pva_pkg::NSTEPS - 1);
	localparam logic signed [24:0] ZMAX = 25'sd5898240;

	state_t state_q;
	logic [4:0] cnt_q;
	logic restart_q;
	logic [23:0] mag_q;
	logic [1:0]  quad_q;
	logic [13:0] rem_q;

	logic signed [35:0] rx_q, ry_q;
	logic signed [24:0] rz_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic signed [41:0] vx_q, vy_q;
	logic signed [24:0] vz_q;
	logic [44:0] plo_q;
	logic [43:0] phi_q;
	logic [31:0] res_mag_q;
	logic [15:0] res_dir_q;
	logic out_valid_q;

	logic [55:0] prod;
	logic signed [24:0] atn;
	logic signed [35:0] rdx, rdy;
	logic signed [35:0] rxr, ryr;
	logic signed [27:0] px, py, cx, cy;
	logic signed [31:0] base_x, base_y;
	logic signed [32:0] nx, ny;
	logic signed [41:0] vdx, vdy;
	logic [40:0] xc;
	logic [31:0] ax, ay;
	logic [65:0] msum;
	logic signed [24:0] zc;
	logic [24:0] zr;
	logic [15:0] d, rd;
	logic load_out;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return v[31:0];
	endfunction

	always_comb begin
		prod = {32'd0, mag_q} * {24'd0, pva_pkg::GAIN_Q32};
		atn  = {2'b00, pva_pkg::atan_val(cnt_q)};
		rdx  = ry_q >>> cnt_q;
		rdy  = rx_q >>> cnt_q;
		vdx  = vy_q >>> cnt_q;
		vdy  = vx_q >>> cnt_q;

		// round the rotated components to integers, dropping their 8 fraction bits
		rxr = rx_q + 36'sd128;
		ryr = ry_q + 36'sd128;
		if (rem_q == 14'd0) begin
			px = {4'd0, mag_q};
			py = 28'sd0;
		end else begin
			px = rxr[35:8];
			py = ryr[35:8];
		end
		case (quad_q)
			pva_pkg::QUAD_I:   begin cx = px;  cy = py;  end
			pva_pkg::QUAD_II:  begin cx = -py; cy = px;  end
			pva_pkg::QUAD_III: begin cx = -px; cy = -py; end
			default:           begin cx = py;  cy = -px; end
		endcase
		base_x = restart_q ? 32'sd0 : acc_x_q;
		base_y = restart_q ? 32'sd0 : acc_y_q;
		nx = {base_x[31], base_x} + 33'(cx);
		ny = {base_y[31], base_y} + 33'(cy);

		ax = acc_x_q[31] ? 32'(-acc_x_q) : acc_x_q;
		ay = acc_y_q[31] ? 32'(-acc_y_q) : acc_y_q;

		xc = vx_q[41] ? 41'd0 : vx_q[40:0];
		msum = {1'b0, phi_q, 21'd0} + {21'd0, plo_q} + 66'h8000_0000;

		if (vz_q < 25'sd0) begin
			zc = 25'sd0;
		end else if (vz_q > ZMAX) begin
			zc = ZMAX;
		end else begin
			zc = vz_q;
		end
		zr = zc + 25'sd256;
		d  = zr[24:9];
		if (!acc_x_q[31] && !acc_y_q[31]) begin
			rd = d;
		end else if (acc_x_q[31] && !acc_y_q[31]) begin
			rd = pva_pkg::DEG180 - d;
		end else if (acc_x_q[31]) begin
			rd = pva_pkg::DEG180 + d;
		end else begin
			rd = pva_pkg::DEG360 - d;
		end
		if (rd >= pva_pkg::DEG360) begin
			rd = rd - pva_pkg::DEG360;
		end
	end

	assign item_pop      = (state_q == S_IDLE) && item_valid;
	assign load_out      = (state_q == S_DONE) && (!out_valid_q || pop);
	assign empty         = !out_valid_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mag_q  <= item.mag;
				quad_q <= item.quad;
				rem_q  <= item.rem;
				restart_q <= item.restart;
			end
			S_MUL: begin
				rx_q <= {4'd0, prod[55:24]};
				ry_q <= 36'sd0;
				rz_q <= {2'b00, rem_q, 9'd0};
			end
			S_ROT: begin
				if (!rz_q[24]) begin
					rx_q <= rx_q - rdx;
					ry_q <= ry_q + rdy;
					rz_q <= rz_q - atn;
				end else begin
					rx_q <= rx_q + rdx;
					ry_q <= ry_q - rdy;
					rz_q <= rz_q + atn;
				end
			end
			S_VINIT: begin
				vx_q <= {2'b00, ax, 8'd0};
				vy_q <= {2'b00, ay, 8'd0};
				vz_q <= 25'sd0;
				if (ax == 32'd0 && ay == 32'd0) begin
					res_mag_q <= 32'd0;
					res_dir_q <= 16'd0;
				end else if (ay == 32'd0) begin
					res_mag_q <= ax;
					res_dir_q <= acc_x_q[31] ? pva_pkg::DEG180 : 16'd0;
				end else if (ax == 32'd0) begin
					res_mag_q <= ay;
					res_dir_q <= acc_y_q[31] ? pva_pkg::DEG270 : pva_pkg::DEG90;
				end
			end
			S_VEC: begin
				if (!vy_q[41]) begin
					vx_q <= vx_q + vdx;
					vy_q <= vy_q - vdy;
					vz_q <= vz_q + atn;
				end else begin
					vx_q <= vx_q - vdx;
					vy_q <= vy_q + vdy;
					vz_q <= vz_q - atn;
				end
			end
			S_MLO: plo_q <= {24'd0, xc[20:0]} * {21'd0, pva_pkg::GAIN_Q24};
			S_MHI: phi_q <= {24'd0, xc[40:21]} * {20'd0, pva_pkg::GAIN_Q24};
			S_FIN: begin
				res_mag_q <= (msum[65:64] != 2'd0) ? 32'hffff_ffff : msum[63:32];
				res_dir_q <= rd;
			end
			default: ;
		endcase
		if (load_out) begin
			sum_x         <= acc_x_q;
			sum_y         <= acc_y_q;
			sum_magnitude <= res_mag_q;
			sum_direction <= res_dir_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 5'd0;
			acc_x_q     <= 32'sd0;
			acc_y_q     <= 32'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (item_valid) begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q   <= 5'd0;
					state_q <= (rem_q == 14'd0) ? S_ACC : S_ROT;
				end
				S_ROT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					acc_x_q <= sat32(nx);
					acc_y_q <= sat32(ny);
					state_q <= S_VINIT;
				end
				S_VINIT: begin
					cnt_q <= 5'd0;
					if (ax == 32'd0 || ay == 32'd0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_VEC;
					end
				end
				S_VEC: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST) begin
						state_q <= S_MLO;
					end
				end
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= S_FIN;
				S_FIN: state_q <= S_DONE;
				S_DONE: if (load_out) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/polar_vector_accumulator.sv]
// top level of the polar vector accumulator: front, queue and back
// the back end takes a new item only once the last result has gone to the output
// register; one sequencer runs the rotation and vectoring passes one step per cycle
// a two-entry queue takes new items while the back end works; a finished result
// waits in the output register
// reset (arst_n low, asynchronous) clears the running sum, queue and result valid flag
module polar_vector_accumulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               restart,
	input  logic [23:0]        vec_magnitude,
	input  logic [15:0]        vec_direction,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] sum_x,
	output logic signed [31:0] sum_y,
	output logic [31:0]        sum_magnitude,
	output logic [15:0]        sum_direction
);

	// classified input item, and the queue head seen by the back end
	pva_pkg::item_t front_item;
	pva_pkg::item_t head_item;
	logic           q_empty;
	logic           q_pop;

	// front end folds the direction into a quadrant and a remainder
	pva_front u_front (
		.restart       (restart),
		.vec_magnitude (vec_magnitude),
		.vec_direction (vec_direction),
		.item          (front_item)
	);

	// queue decouples input transfers from the cordic sequencer
	pva_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_item (front_item),
		.full    (full),
		.rd      (q_pop),
		.rd_item (head_item),
		.empty   (q_empty)
	);

	// back end runs rotation, accumulate and vectoring, then holds the result
	pva_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (head_item),
		.item_valid    (!q_empty),
		.item_pop      (q_pop),
		.sum_x         (sum_x),
		.sum_y         (sum_y),
		.sum_magnitude (sum_magnitude),
		.sum_direction (sum_direction),
		.empty         (empty),
		.pop           (pop)
	);

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the polar vector accumulator
`timescale 1ns / 100ps
module tb;

	// one vector to add, as offered on the input side
	typedef struct {
		logic        restart;
		logic [23:0] mag;
		logic [15:0] dir;
	} vec_t;

	// one expected running sum, as seen on the result side
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        mag;
		logic [15:0]        dir;
	} sum_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic               restart;
	logic [23:0]        vec_magnitude;
	logic [15:0]        vec_direction;
	logic               empty;
	logic               pop;
	logic signed [31:0] sum_x;
	logic signed [31:0] sum_y;
	logic [31:0]        sum_magnitude;
	logic [15:0]        sum_direction;

	polar_vector_accumulator u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.restart(restart), .vec_magnitude(vec_magnitude), .vec_direction(vec_direction),
		.empty(empty), .pop(pop), .sum_x(sum_x), .sum_y(sum_y),
		.sum_magnitude(sum_magnitude), .sum_direction(sum_direction)
	);

	localparam int CYCLE_LIMIT = 3000000;

	vec_t   pending_vecs[$];  // vectors still to be offered
	sum_t   expected_sums[$]; // predicted sums, oldest first
	longint run_x = 0;        // predictor copy of the running sum
	longint run_y = 0;
	int     mismatches = 0;
	int     transfers_in = 0;
	int     transfers_out = 0;
	int     n_restart = 0;
	int     n_axis = 0;
	int     n_wrap = 0;
	int     n_sat = 0;
	longint cycles = 0;
	bit     stim_done;
	bit     hold_rx;          // long receiver hold-off request
	bit     pause_tx;         // sender waits for the result side to drain
	int     tx_gap, rx_gap;

	// append one vector to the stimulus queue
	task automatic add_vec(input vec_t v);
		pending_vecs.insert(pending_vecs.size(), v);
	endtask

	// atan(2^-i) in 1/65536 degree
	function automatic longint arctan_step(int i);
		longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
		return (i < 23) ? t[i] : 0;
	endfunction

	function automatic int step_count();
		return (pva_pkg::CORDIC_STEPS > 32) ? 32 : pva_pkg::CORDIC_STEPS;
	endfunction

	// >>> on a signed longint rounds toward minus infinity, which is what we want
	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// polar to components, folding the direction into the first quadrant
	task automatic polar_to_xy(input longint m, input int d, output longint ox,
			output longint oy);
		int     q, r;
		longint px, py, x, y, z, dx, dy;
		q = d / 11520;
		r = d % 11520;
		if (r == 0) begin
			px = m;
			py = 0;
		end else begin
			x = longint'((64'(m) * 64'(pva_pkg::GAIN_Q32)) >> 24);
			y = 0;
			z = longint'(r) * 512;
			for (int i = 0; i < step_count(); i++) begin
				dx = shr(y, i);
				dy = shr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= arctan_step(i);
				end else begin
					x += dx; y -= dy; z += arctan_step(i);
				end
			end
			px = shr(x + 128, 8);
			py = shr(y + 128, 8);
		end
		case (q)
			0: begin ox = px;  oy = py;  end
			1: begin ox = -py; oy = px;  end
			2: begin ox = -px; oy = -py; end
			default: begin ox = py; oy = -px; end
		endcase
	endtask

	// first-quadrant vectoring pass, both inputs positive
	task automatic xy_to_polar(input longint ax, input longint ay, output logic [31:0] om,
			output int oa);
		longint      x, y, z, dx, dy;
		logic [63:0] m;
		x = ax * 256;
		y = ay * 256;
		z = 0;
		for (int i = 0; i < step_count(); i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += arctan_step(i);
			end else begin
				x -= dx; y += dy; z -= arctan_step(i);
			end
		end
		if (x < 0) x = 0;
		m = (64'(x) * 64'(pva_pkg::GAIN_Q24) + 64'h8000_0000) >> 32;
		om = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
		if (z < 0) z = 0;
		if (z > 11520 * 512) z = 11520 * 512;
		oa = int'((z + 256) >>> 9);
	endtask

	// advance the predicted running sum by one vector and queue the result
	task automatic accumulate(input vec_t v);
		sum_t   s;
		longint cx, cy, nx, ny, ax, ay;
		int     d, a;
		logic [31:0] pm;
		d = int'(v.dir);
		if (d >= 46080) begin
			d -= 46080;
			n_wrap++;
		end
		if (d % 11520 == 0) n_axis++;
		if (v.restart) begin
			run_x = 0;
			run_y = 0;
			n_restart++;
		end
		polar_to_xy(longint'(v.mag & pva_pkg::MAG_MASK), d, cx, cy);
		nx = clamp32(run_x + cx);
		ny = clamp32(run_y + cy);
		if (nx != run_x + cx || ny != run_y + cy) n_sat++;
		run_x = nx;
		run_y = ny;
		s.x = run_x[31:0];
		s.y = run_y[31:0];
		if (run_x == 0 && run_y == 0) begin
			s.mag = 32'd0;
			s.dir = 16'd0;
		end else if (run_y == 0) begin
			s.mag = (run_x > 0) ? run_x[31:0] : 32'(-run_x);
			s.dir = (run_x > 0) ? 16'd0 : pva_pkg::DEG180;
		end else if (run_x == 0) begin
			s.mag = (run_y > 0) ? run_y[31:0] : 32'(-run_y);
			s.dir = (run_y > 0) ? pva_pkg::DEG90 : pva_pkg::DEG270;
		end else begin
			ax = (run_x > 0) ? run_x : -run_x;
			ay = (run_y > 0) ? run_y : -run_y;
			xy_to_polar(ax, ay, pm, a);
			s.mag = pm;
			if (run_x < 0 && run_y > 0) a = 23040 - a;
			else if (run_x < 0) a = 23040 + a;
			else if (run_y < 0) a = 46080 - a;
			if (a >= 46080) a -= 46080;
			s.dir = a[15:0];
		end
		expected_sums.insert(expected_sums.size(), s);
	endtask

	// clock and cycle limit
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL polar_vector_accumulator");
			$finish;
		end
	end

	// sender: input changes at the falling edge; a transfer happened at the
	// previous rising edge when push was high and full was low
	bit tx_fire;
	always @(posedge clk) tx_fire <= push && !full && arst_n;

	always @(negedge clk) begin
		if (!arst_n) begin
			push          <= 1'b0;
			restart       <= 1'b0;
			vec_magnitude <= '0;
			vec_direction <= '0;
		end else begin
			if (tx_fire) begin
				accumulate(pending_vecs.pop_front());
				transfers_in++;
				tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
			end
			if (push && !tx_fire) begin
				// keep offering the same vector
			end else if (pending_vecs.size() == 0 || (pause_tx && expected_sums.size() != 0)) begin
				push <= 1'b0;
			end else if (tx_gap > 0) begin
				tx_gap--;
				push <= 1'b0;
			end else begin
				push          <= 1'b1;
				restart       <= pending_vecs[0].restart;
				vec_magnitude <= pending_vecs[0].mag;
				vec_direction <= pending_vecs[0].dir;
			end
		end
	end

	// receiver: pop decided at the falling edge, result checked at the rising edge
	always @(negedge clk) begin
		if (!arst_n || hold_rx) begin
			pop <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sum_t e;
		if (arst_n && pop && !empty) begin
			transfers_out++;
			rx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
			if (expected_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d", sum_x, sum_y);
			end else begin
				e = expected_sums.pop_front();
				if (sum_x !== e.x || sum_y !== e.y || sum_magnitude !== e.mag ||
						sum_direction !== e.dir) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: exp x=%0d y=%0d m=%0d d=%0d got x=%0d y=%0d m=%0d d=%0d",
							transfers_out, e.x, e.y, e.mag, e.dir,
							sum_x, sum_y, sum_magnitude, sum_direction);
				end
			end
		end
	end

	function automatic vec_t mk(bit r, logic [23:0] m, logic [15:0] d);
		vec_t v;
		v.restart = r;
		v.mag = m;
		v.dir = d;
		return v;
	endfunction

	// random vector; mostly in-range directions, sometimes wrapped or on an axis
	function automatic vec_t rand_vec();
		vec_t v;
		int   k;
		v.restart = ($urandom_range(0, 7) == 0);
		k = $urandom_range(0, 9);
		if (k < 2) v.mag = 24'($urandom_range(0, 255));
		else if (k < 4) v.mag = 24'hFFFFFF - 24'($urandom_range(0, 255));
		else v.mag = 24'($urandom);
		k = $urandom_range(0, 9);
		if (k == 0) v.dir = 16'($urandom_range(0, 3) * 11520);
		else if (k == 1) v.dir = 16'($urandom_range(46080, 65535));
		else v.dir = 16'($urandom_range(0, 46079));
		return v;
	endfunction

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: zero, axes, wrap, extremes, cancellation and repeated full-scale vectors
		add_vec(mk(1'b0, 24'd0, 16'd0));
		add_vec(mk(1'b0, 24'd256, 16'd0));
		add_vec(mk(1'b1, 24'd256, pva_pkg::DEG90));
		add_vec(mk(1'b0, 24'd256, pva_pkg::DEG270));
		add_vec(mk(1'b1, 24'hFFFFFF, pva_pkg::DEG180));
		add_vec(mk(1'b0, 24'hFFFFFF, 16'd0));
		add_vec(mk(1'b1, 24'h001000, 16'd1));
		add_vec(mk(1'b0, 24'h001000, 16'd46079));
		add_vec(mk(1'b1, 24'h123456, 16'd46080));
		add_vec(mk(1'b0, 24'h123456, 16'hFFFF));
		add_vec(mk(1'b1, 24'hFFFFFF, 16'd5760));
		add_vec(mk(1'b0, 24'hABCDEF, 16'd17280));
		add_vec(mk(1'b0, 24'h555555, 16'd28800));
		add_vec(mk(1'b0, 24'hAAAAAA, 16'd40320));
		add_vec(mk(1'b1, 24'h000001, 16'd11519));
		for (int i = 0; i < 9; i++)
			add_vec(mk(i == 0, 24'hFFFFFF, 16'd5760));
		wait (pending_vecs.size() == 0 && expected_sums.size() == 0);

		// receiver holds off while the sender keeps offering, so the block fills
		for (int i = 0; i < 40; i++) add_vec(rand_vec());
		hold_rx = 1;
		repeat (400) @(posedge clk);
		hold_rx = 0;
		wait (pending_vecs.size() == 0);

		// sender pauses until every result has come back
		pause_tx = 1;
		for (int i = 0; i < 10; i++) add_vec(rand_vec());
		wait (pending_vecs.size() == 0 && expected_sums.size() == 0);
		pause_tx = 0;

		for (int i = 0; i < 1700; i++) add_vec(rand_vec());
		wait (pending_vecs.size() == 0);
		wait (expected_sums.size() == 0);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		repeat (100) @(posedge clk);
		$display("%0d vectors in, %0d sums out; %0d restarts, %0d on an axis,",
			transfers_in, transfers_out, n_restart, n_axis);
		$display("%0d wrapped directions, %0d saturating sums, %0d mismatches",
			n_wrap, n_sat, mismatches);
		if (mismatches == 0 && expected_sums.size() == 0)
			$display("PASS polar_vector_accumulator");
		else
			$display("FAIL polar_vector_accumulator");
		$finish;
	end

endmodule
